@@ sv/mlrr_pkg.sv @@
package mlrr_pkg;

	localparam int LEVELS    = 8;
	localparam int MAX_TASKS = 64;
	localparam int LV_W      = 3;
	localparam int ID_W      = 6;
	localparam int CNT_W     = 7;
	localparam int EV_W      = 8;
	localparam int DATA_W    = 32;

	// Request kinds
	localparam logic [2:0] KIND_INSERT  = 3'd0;
	localparam logic [2:0] KIND_REMOVE  = 3'd1;
	localparam logic [2:0] KIND_NEXT    = 3'd2;
	localparam logic [2:0] KIND_SETST   = 3'd3;
	localparam logic [2:0] KIND_UNBLOCK = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPRIO  = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_NOREADY  = 3'd4;
	localparam logic [2:0] ST_DUPFULL  = 3'd5;

	// Task states
	localparam logic [1:0] TS_READY  = 2'd0;
	localparam logic [1:0] TS_ACTIVE = 2'd1;
	localparam logic [1:0] TS_WAIT   = 2'd2;

	typedef struct packed {
		logic [2:0]               kind;
		logic [ID_W-1:0]          task_id;
		logic [LV_W-1:0]          priority_req;
		logic [1:0]               task_state;
		logic [EV_W-1:0]          event_id;
		logic signed [DATA_W-1:0] ev_payload;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [ID_W-1:0]          task_id_res;
		logic signed [DATA_W-1:0] event_data_res;
		logic                     woke;
		logic                     last;
	} out_beat_t;

endpackage

@@ sv/mlrr_out_buf.sv @@
module mlrr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mlrr_pkg::out_beat_t load_data,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output mlrr_pkg::out_beat_t out_data
);

	logic                valid_q;
	mlrr_pkg::out_beat_t data_q;

	// free when empty or when the held beat leaves this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ sv/multilevel_round_robin_scheduler_unit.sv @@
// Channel | signals                          | beat
// in      | in_valid, in_ready, in_data       | one request (insert/remove/next/set/unblock)
// out     | out_valid, out_ready, out_data    | one result; last marks the final one
//
// One request at a time: in_ready is high only when the sequencer is idle.
// Insert and set_state need no walk; remove walks the queued tasks of its level,
// next visits the levels from 0 and walks each queued task up to a runnable one,
// and unblock visits every level and every queued task.
// The single read port of the link memory gives one hop a cycle unless unblock holds.
// A full output register stalls the sequencer; a new request is still taken
// while the last result waits. Reset is instant: no clearing pass.
module multilevel_round_robin_scheduler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mlrr_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mlrr_pkg::out_beat_t out_data
);

	localparam int LEVELS    = mlrr_pkg::LEVELS;
	localparam int MAX_TASKS = mlrr_pkg::MAX_TASKS;
	localparam int LV_W      = mlrr_pkg::LV_W;
	localparam int ID_W      = mlrr_pkg::ID_W;
	localparam int CNT_W     = mlrr_pkg::CNT_W;
	localparam int EV_W      = mlrr_pkg::EV_W;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_DEC      = 10'b00_0000_0010,
		S_RM_START = 10'b00_0000_0100,
		S_RM_CHK   = 10'b00_0000_1000,
		S_NX_LVL   = 10'b00_0001_0000,
		S_NX_CHK   = 10'b00_0010_0000,
		S_UB_LVL   = 10'b00_0100_0000,
		S_UB_CHK   = 10'b00_1000_0000,
		S_UB_END   = 10'b01_0000_0000,
		S_EMIT     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	mlrr_pkg::in_beat_t  req_q;
	mlrr_pkg::out_beat_t res_q, res_d;

	// per-level queue descriptors
	logic [ID_W-1:0]  head_q  [LEVELS];
	logic [ID_W-1:0]  head_d  [LEVELS];
	logic [ID_W-1:0]  tail_q  [LEVELS];
	logic [ID_W-1:0]  tail_d  [LEVELS];
	logic [CNT_W-1:0] count_q [LEVELS];
	logic [CNT_W-1:0] count_d [LEVELS];
	logic [CNT_W-1:0] total_q, total_d;
	logic [MAX_TASKS-1:0] present_q, present_d;

	// walk registers
	logic [LV_W-1:0]  lv_q, lv_d;
	logic [ID_W-1:0]  cur_q, cur_d;
	logic [ID_W-1:0]  prev_q, prev_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic             pend_v_q, pend_v_d;
	logic [ID_W-1:0]  pend_id_q, pend_id_d;

	// task memories, one shared read address
	logic [ID_W-1:0]      link_mem [MAX_TASKS];
	logic [LV_W-1:0]      lvl_mem  [MAX_TASKS];
	logic [EV_W+1:0]      st_mem   [MAX_TASKS];
	logic [MAX_TASKS-1:0] st_vld_q, st_vld_d;

	logic [ID_W-1:0] rd_addr;
	logic [ID_W-1:0] link_rd_q;
	logic [LV_W-1:0] lvl_rd_q;
	logic [EV_W+1:0] st_rd_q;

	logic            link_we;
	logic [ID_W-1:0] link_wa, link_wd;
	logic            lvl_we;
	logic            st_we;
	logic [ID_W-1:0] st_wa;
	logic [EV_W+1:0] st_wd;

	logic                obuf_load, obuf_free;
	mlrr_pkg::out_beat_t obuf_data;

	logic [ID_W-1:0]  hd, tl;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] step_inc;
	logic             lv_last;
	logic             match;
	logic [1:0]       rd_status;

	assign hd        = head_q[lv_q];
	assign tl        = tail_q[lv_q];
	assign cnt       = count_q[lv_q];
	assign step_inc  = step_q + CNT_W'(1);
	assign lv_last   = (lv_q == LV_W'(LEVELS - 1));
	assign rd_status = st_rd_q[EV_W+1:EV_W];
	assign match     = (rd_status == mlrr_pkg::TS_WAIT) && (st_rd_q[EV_W-1:0] == req_q.event_id);
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		total_d   = total_q;
		present_d = present_q;
		st_vld_d  = st_vld_q;
		lv_d      = lv_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		step_d    = step_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		rd_addr   = cur_q;
		link_we   = 1'b0;
		link_wa   = tl;
		link_wd   = req_q.task_id;
		lvl_we    = 1'b0;
		st_we     = 1'b0;
		st_wa     = req_q.task_id;
		st_wd     = '0;
		obuf_load = 1'b0;
		obuf_data = res_q;

		case (state_q)
			S_IDLE: begin
				// read the named task's entries while decoding
				rd_addr = in_data.task_id;
				if (in_valid) begin
					lv_d     = in_data.priority_req;
					pend_v_d = 1'b0;
					res_d    = '0;
					res_d.last = 1'b1;
					state_d  = S_DEC;
				end
			end

			S_DEC: begin
				state_d = S_EMIT;
				case (req_q.kind)
					mlrr_pkg::KIND_INSERT: begin
						if (int'(req_q.priority_req) >= LEVELS) begin
							res_d.status = mlrr_pkg::ST_BADPRIO;
						end else if (present_q[req_q.task_id]
							|| total_q >= CNT_W'(MAX_TASKS)) begin
							res_d.status = mlrr_pkg::ST_DUPFULL;
						end else begin
							res_d.status = mlrr_pkg::ST_OK;
							present_d[req_q.task_id] = 1'b1;
							lvl_we = 1'b1;
							if (cnt == '0) begin
								head_d[lv_q] = req_q.task_id;
							end else begin
								link_we = 1'b1;
							end
							tail_d[lv_q]  = req_q.task_id;
							count_d[lv_q] = cnt + CNT_W'(1);
							total_d       = total_q + CNT_W'(1);
						end
					end
					mlrr_pkg::KIND_REMOVE: begin
						if (total_q == '0) begin
							res_d.status = mlrr_pkg::ST_EMPTY;
						end else if (!present_q[req_q.task_id]) begin
							res_d.status = mlrr_pkg::ST_NOTFOUND;
						end else begin
							lv_d    = lvl_rd_q;
							state_d = S_RM_START;
						end
					end
					mlrr_pkg::KIND_NEXT: begin
						lv_d    = '0;
						state_d = S_NX_LVL;
					end
					mlrr_pkg::KIND_SETST: begin
						st_we = 1'b1;
						st_wd = {req_q.task_state,
							(req_q.task_state == mlrr_pkg::TS_WAIT) ? req_q.event_id : EV_W'(0)};
						res_d.status = mlrr_pkg::ST_OK;
					end
					mlrr_pkg::KIND_UNBLOCK: begin
						lv_d    = '0;
						state_d = S_UB_LVL;
					end
					default: begin
						// unknown kinds give no result
						state_d = S_IDLE;
					end
				endcase
			end

			S_RM_START: begin
				cur_d   = hd;
				prev_d  = hd;
				step_d  = '0;
				rd_addr = hd;
				if (cnt == '0) begin
					res_d.status = mlrr_pkg::ST_NOTFOUND;
					state_d = S_EMIT;
				end else begin
					state_d = S_RM_CHK;
				end
			end

			S_RM_CHK: begin
				if (cur_q == req_q.task_id) begin
					// unlink: predecessor or head takes the successor
					if (step_q == '0) begin
						head_d[lv_q] = link_rd_q;
					end else begin
						link_we = 1'b1;
						link_wa = prev_q;
						link_wd = link_rd_q;
					end
					if (step_inc == cnt) begin
						tail_d[lv_q] = prev_q;
					end
					count_d[lv_q] = cnt - CNT_W'(1);
					present_d[req_q.task_id] = 1'b0;
					total_d = total_q - CNT_W'(1);
					res_d.status = mlrr_pkg::ST_OK;
					state_d = S_EMIT;
				end else if (step_inc >= cnt) begin
					res_d.status = mlrr_pkg::ST_NOTFOUND;
					state_d = S_EMIT;
				end else begin
					prev_d  = cur_q;
					cur_d   = link_rd_q;
					rd_addr = link_rd_q;
					step_d  = step_inc;
				end
			end

			S_NX_LVL: begin
				step_d  = '0;
				rd_addr = hd;
				if (cnt != '0) begin
					state_d = S_NX_CHK;
				end else if (lv_last) begin
					res_d.status = mlrr_pkg::ST_NOREADY;
					state_d = S_EMIT;
				end else begin
					lv_d = lv_q + LV_W'(1);
				end
			end

			S_NX_CHK: begin
				rd_addr = hd;
				// rotate head to tail
				if (cnt > CNT_W'(1)) begin
					head_d[lv_q] = link_rd_q;
					link_we = 1'b1;
					link_wa = tl;
					link_wd = hd;
					tail_d[lv_q] = hd;
					rd_addr = link_rd_q;
				end
				if (rd_status == mlrr_pkg::TS_READY || rd_status == mlrr_pkg::TS_ACTIVE) begin
					res_d.status      = mlrr_pkg::ST_OK;
					res_d.task_id_res = hd;
					state_d = S_EMIT;
				end else if (step_inc >= cnt) begin
					if (lv_last) begin
						res_d.status = mlrr_pkg::ST_NOREADY;
						state_d = S_EMIT;
					end else begin
						lv_d    = lv_q + LV_W'(1);
						state_d = S_NX_LVL;
					end
				end else begin
					step_d = step_inc;
				end
			end

			S_UB_LVL: begin
				step_d  = '0;
				cur_d   = hd;
				rd_addr = hd;
				if (cnt != '0) begin
					state_d = S_UB_CHK;
				end else if (lv_last) begin
					state_d = S_UB_END;
				end else begin
					lv_d = lv_q + LV_W'(1);
				end
			end

			S_UB_CHK: begin
				if (match && pend_v_q && !obuf_free) begin
					// hold until the previous woken beat can go out
					rd_addr = cur_q;
				end else begin
					if (match) begin
						st_we = 1'b1;
						st_wa = cur_q;
						st_wd = '0;
						if (pend_v_q) begin
							obuf_load = 1'b1;
							obuf_data = '0;
							obuf_data.status         = mlrr_pkg::ST_OK;
							obuf_data.task_id_res    = pend_id_q;
							obuf_data.event_data_res = req_q.ev_payload;
							obuf_data.woke           = 1'b1;
						end
						pend_v_d  = 1'b1;
						pend_id_d = cur_q;
					end
					if (step_inc >= cnt) begin
						if (lv_last) begin
							state_d = S_UB_END;
						end else begin
							lv_d    = lv_q + LV_W'(1);
							state_d = S_UB_LVL;
						end
					end else begin
						step_d  = step_inc;
						cur_d   = link_rd_q;
						rd_addr = link_rd_q;
					end
				end
			end

			S_UB_END: begin
				res_d.status = mlrr_pkg::ST_OK;
				if (pend_v_q) begin
					res_d.task_id_res    = pend_id_q;
					res_d.event_data_res = req_q.ev_payload;
					res_d.woke           = 1'b1;
				end
				state_d = S_EMIT;
			end

			S_EMIT: begin
				if (obuf_free) begin
					obuf_load = 1'b1;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (st_we) begin
			st_vld_d[st_wa] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '{default: '0};
			tail_q    <= '{default: '0};
			count_q   <= '{default: '0};
			total_q   <= '0;
			present_q <= '0;
			st_vld_q  <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			total_q   <= total_d;
			present_q <= present_d;
			st_vld_q  <= st_vld_d;
			pend_v_q  <= pend_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_q <= in_data;
		end
		res_q     <= res_d;
		lv_q      <= lv_d;
		cur_q     <= cur_d;
		prev_q    <= prev_d;
		step_q    <= step_d;
		pend_id_q <= pend_id_d;
	end

	// task memories; a same-cycle write forwards to the read, but not in the level memory
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= (link_we && link_wa == rd_addr) ? link_wd : link_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_mem[req_q.task_id] <= req_q.priority_req;
		end
		lvl_rd_q <= lvl_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		if (st_we && st_wa == rd_addr) begin
			st_rd_q <= st_wd;
		end else if (st_vld_q[rd_addr]) begin
			st_rd_q <= st_mem[rd_addr];
		end else begin
			st_rd_q <= '0;
		end
	end

	mlrr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (obuf_load),
		.load_data (obuf_data),
		.free      (obuf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(present_q) == int'(total_q))
		else $error("task total out of step with presence bits");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_load |-> obuf_free)
		else $error("result beat loaded over a waiting beat");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int         LEVELS        = mlrr_pkg::LEVELS;
	localparam int         MAX_TASKS     = mlrr_pkg::MAX_TASKS;
	localparam int         ID_W          = mlrr_pkg::ID_W;
	localparam int         LV_W          = mlrr_pkg::LV_W;
	localparam int         IN_W          = $bits(mlrr_pkg::in_beat_t);
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam logic [1:0] TS_BLOCKED    = 2'd3;
	localparam int         CYCLE_LIMIT   = 1_000_000;
	localparam int         DRAIN_CYCLES  = 200;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mlrr_pkg::in_beat_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	mlrr_pkg::out_beat_t out_data;

	multilevel_round_robin_scheduler_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// Scheduler shadow state
	int        q_head [LEVELS];
	int        q_tail [LEVELS];
	int        q_cnt  [LEVELS];
	int        link   [MAX_TASKS];
	bit        queued [MAX_TASKS];
	int        lvl_of [MAX_TASKS];
	logic [1:0] tstate [MAX_TASKS];
	logic [7:0] awaited [MAX_TASKS];
	int        n_queued;

	mlrr_pkg::out_beat_t fresh_results [$];
	mlrr_pkg::out_beat_t pending [$];

	int  errors;
	int  cycles;
	int  sender_idle_pct;
	int  recv_stall_pct;
	int  hold_cnt;

	function automatic mlrr_pkg::out_beat_t mk_res(logic [2:0] st, int id, logic [31:0] d,
			bit w, bit l);
		mlrr_pkg::out_beat_t r;
		r.status = st;
		r.task_id_res = id[ID_W-1:0];
		r.event_data_res = d;
		r.woke = w;
		r.last = l;
		return r;
	endfunction

	function automatic logic [2:0] sched_insert(int id, int prio);
		if (prio >= LEVELS)
			return mlrr_pkg::ST_BADPRIO;
		if (id >= MAX_TASKS || queued[id] || n_queued >= MAX_TASKS)
			return mlrr_pkg::ST_DUPFULL;
		queued[id] = 1'b1;
		lvl_of[id] = prio;
		if (q_cnt[prio] == 0)
			q_head[prio] = id;
		else
			link[q_tail[prio]] = id;
		q_tail[prio] = id;
		q_cnt[prio]++;
		n_queued++;
		return mlrr_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] sched_remove(int id);
		int lv, cur, prv;
		if (n_queued == 0)
			return mlrr_pkg::ST_EMPTY;
		if (id >= MAX_TASKS || !queued[id])
			return mlrr_pkg::ST_NOTFOUND;
		lv = lvl_of[id];
		cur = q_head[lv];
		prv = cur;
		for (int i = 0; i < q_cnt[lv]; i++) begin
			if (cur == id) begin
				if (i == 0)
					q_head[lv] = link[cur];
				else
					link[prv] = link[cur];
				if (i + 1 == q_cnt[lv])
					q_tail[lv] = prv;
				q_cnt[lv]--;
				queued[id] = 1'b0;
				n_queued--;
				return mlrr_pkg::ST_OK;
			end
			prv = cur;
			cur = link[cur];
		end
		return mlrr_pkg::ST_NOTFOUND;
	endfunction

	// Rotate heads to tails until a runnable task turns up; -1 if none
	function automatic int sched_next();
		int h;
		for (int lv = 0; lv < LEVELS; lv++) begin
			for (int j = 0; j < q_cnt[lv]; j++) begin
				h = q_head[lv];
				if (q_cnt[lv] > 1) begin
					q_head[lv] = link[h];
					link[q_tail[lv]] = h;
					q_tail[lv] = h;
				end
				if (tstate[h] == mlrr_pkg::TS_READY || tstate[h] == mlrr_pkg::TS_ACTIVE)
					return h;
			end
		end
		return -1;
	endfunction

	function automatic void sched_unblock(logic [7:0] ev, logic [31:0] d);
		int cur;
		for (int lv = 0; lv < LEVELS; lv++) begin
			cur = q_head[lv];
			for (int j = 0; j < q_cnt[lv]; j++) begin
				if (tstate[cur] == mlrr_pkg::TS_WAIT && awaited[cur] == ev) begin
					tstate[cur] = mlrr_pkg::TS_READY;
					awaited[cur] = '0;
					fresh_results.push_back(mk_res(mlrr_pkg::ST_OK, cur, d, 1'b1, 1'b0));
				end
				cur = link[cur];
			end
		end
		if (fresh_results.size() == 0)
			fresh_results.push_back(mk_res(mlrr_pkg::ST_OK, 0, '0, 1'b0, 1'b1));
		else
			fresh_results[fresh_results.size()-1].last = 1'b1;
	endfunction

	// Advance the shadow state by one request; results land in fresh_results
	function automatic void sched_apply(mlrr_pkg::in_beat_t b);
		int id, pick;
		id = b.task_id;
		fresh_results.delete();
		case (b.kind)
			mlrr_pkg::KIND_INSERT:
				fresh_results.push_back(mk_res(sched_insert(id, b.priority_req), 0, '0, 0, 1));
			mlrr_pkg::KIND_REMOVE:
				fresh_results.push_back(mk_res(sched_remove(id), 0, '0, 0, 1));
			mlrr_pkg::KIND_NEXT: begin
				pick = sched_next();
				if (pick < 0)
					fresh_results.push_back(mk_res(mlrr_pkg::ST_NOREADY, 0, '0, 0, 1));
				else
					fresh_results.push_back(mk_res(mlrr_pkg::ST_OK, pick, '0, 0, 1));
			end
			mlrr_pkg::KIND_SETST: begin
				tstate[id] = b.task_state;
				awaited[id] = (b.task_state == mlrr_pkg::TS_WAIT) ? b.event_id : 8'h00;
				fresh_results.push_back(mk_res(mlrr_pkg::ST_OK, 0, '0, 0, 1));
			end
			mlrr_pkg::KIND_UNBLOCK:
				sched_unblock(b.event_id, b.ev_payload);
			default: ;
		endcase
	endfunction

	function automatic mlrr_pkg::in_beat_t mk_req(logic [2:0] k, int id, int prio,
			logic [1:0] st, logic [7:0] ev, logic [31:0] d);
		mlrr_pkg::in_beat_t b;
		b.kind = k;
		b.task_id = id[ID_W-1:0];
		b.priority_req = prio[LV_W-1:0];
		b.task_state = st;
		b.event_id = ev;
		b.ev_payload = d;
		return b;
	endfunction

	// Hold the beat until accepted; typed rows replace the shadow's results
	task automatic send(mlrr_pkg::in_beat_t b, bit typed = 1'b0,
			logic [2:0] typed_st = mlrr_pkg::ST_OK);
		while (sender_idle_pct > 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sched_apply(b);
		if (typed)
			pending.push_back(mk_res(typed_st, 0, '0, 1'b0, 1'b1));
		else
			foreach (fresh_results[i])
				pending.push_back(fresh_results[i]);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_event();
		case ($urandom_range(0, 7))
			0, 1: return 8'h00;
			2, 3: return 8'hFF;
			4: return 8'h5A;
			5: return 8'hA5;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_queued_id();
		for (int tries = 0; tries < 8; tries++) begin
			int id = $urandom_range(0, MAX_TASKS - 1);
			if (queued[id])
				return id;
		end
		return $urandom_range(0, MAX_TASKS - 1);
	endfunction

	function automatic mlrr_pkg::in_beat_t rand_req();
		mlrr_pkg::in_beat_t b;
		logic [63:0] raw;
		int r, ins_w;
		raw = {$urandom, $urandom};
		b = raw[IN_W-1:0];
		ins_w = (n_queued < 24) ? 40 : 15;
		r = $urandom_range(0, 99);
		if (r < 3)
			b.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		else if (r < 3 + ins_w)
			b.kind = mlrr_pkg::KIND_INSERT;
		else if (r < 15 + ins_w) begin
			b.kind = mlrr_pkg::KIND_REMOVE;
			b.task_id = ID_W'(pick_queued_id());
		end else if (r < 40 + ins_w)
			b.kind = mlrr_pkg::KIND_NEXT;
		else if (r < 70 + ins_w) begin
			b.kind = mlrr_pkg::KIND_SETST;
			b.task_id = ID_W'(pick_queued_id());
			b.event_id = pick_event();
		end else begin
			b.kind = mlrr_pkg::KIND_UNBLOCK;
			b.event_id = pick_event();
		end
		return b;
	endfunction

	// Receiver: a long hold-off when requested, otherwise random stalls
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
		end
	end

	// Check every result beat against the oldest expectation
	always @(posedge clk) begin
		mlrr_pkg::out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %p", out_data);
			end else begin
				e = pending.pop_front();
				if (out_data !== e) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		mlrr_pkg::in_beat_t dir_req [$];
		bit                 dir_typed [$];
		logic [2:0]         dir_st [$];
		foreach (q_cnt[i]) begin
			q_head[i] = 0;
			q_tail[i] = 0;
			q_cnt[i] = 0;
		end
		foreach (queued[i]) begin
			link[i] = 0;
			queued[i] = 0;
			lvl_of[i] = 0;
			tstate[i] = mlrr_pkg::TS_READY;
			awaited[i] = '0;
		end
		n_queued = 0;
		errors = 0;
		cycles = 0;
		hold_cnt = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;

		// Directed rows: status typed where it is obvious, else shadow-checked
		dir_req = '{
			mk_req(mlrr_pkg::KIND_REMOVE, 5, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_NEXT, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_UNBLOCK, 0, 0, 0, 8'h00, 32'h1234_5678),
			mk_req(mlrr_pkg::KIND_INSERT, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_INSERT, 63, 7, 3, 8'hFF, 32'hFFFF_FFFF),
			mk_req(mlrr_pkg::KIND_INSERT, 0, 3, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_REMOVE, 10, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_SETST, 63, 0, TS_BLOCKED, 8'h77, 0),
			mk_req(mlrr_pkg::KIND_NEXT, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_SETST, 0, 0, mlrr_pkg::TS_WAIT, 8'hFF, 0),
			mk_req(mlrr_pkg::KIND_NEXT, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_INSERT, 5, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_SETST, 9, 0, mlrr_pkg::TS_ACTIVE, 8'h33, 0),
			mk_req(mlrr_pkg::KIND_INSERT, 9, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_NEXT, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_UNBLOCK, 0, 0, 0, 8'hFF, 32'h8000_0000),
			mk_req(mlrr_pkg::KIND_UNBLOCK, 0, 0, 0, 8'hFF, 32'h7FFF_FFFF),
			mk_req(KIND_SPARE_LO, 1, 1, 1, 1, 1),
			mk_req(KIND_SPARE_HI, 2, 2, 2, 2, 2),
			mk_req(mlrr_pkg::KIND_SETST, 5, 0, mlrr_pkg::TS_WAIT, 8'h00, 0),
			mk_req(mlrr_pkg::KIND_UNBLOCK, 0, 0, 0, 8'h00, 32'hFFFF_FFFF),
			mk_req(mlrr_pkg::KIND_REMOVE, 0, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_REMOVE, 63, 0, 0, 0, 0),
			mk_req(mlrr_pkg::KIND_NEXT, 0, 0, 0, 0, 0)
		};
		dir_typed = '{1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0,
			1, 0, 1, 1, 0};
		dir_st = '{mlrr_pkg::ST_EMPTY, mlrr_pkg::ST_NOREADY, mlrr_pkg::ST_OK,
			mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_DUPFULL, mlrr_pkg::ST_NOTFOUND,
			mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_NOREADY,
			mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK,
			mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK,
			mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK, mlrr_pkg::ST_OK,
			mlrr_pkg::ST_OK};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_req[i])
			send(dir_req[i], dir_typed[i], dir_st[i]);

		// No idling
		repeat (60) send(rand_req());
		in_valid <= 1'b0;
		wait (pending.size() == 0);
		@(negedge clk);

		// Sender idle; first fill the queues, then wake every task at once
		sender_idle_pct = 56;
		for (int id = 0; id < MAX_TASKS; id++)
			send(mk_req(mlrr_pkg::KIND_INSERT, id, $urandom_range(0, LEVELS - 1), 0, 0,
				$urandom));
		send(mk_req(mlrr_pkg::KIND_INSERT, $urandom_range(0, 63), 0, 0, 0, 0));
		for (int id = 0; id < MAX_TASKS; id++)
			send(mk_req(mlrr_pkg::KIND_SETST, id, 0, mlrr_pkg::TS_WAIT, 8'h3C, 0));
		send(mk_req(mlrr_pkg::KIND_UNBLOCK, 0, 0, 0, 8'h3C, $urandom));
		repeat (30) send(rand_req());
		in_valid <= 1'b0;
		wait (pending.size() == 0);
		@(negedge clk);

		// Receiver stalls, starting with a long hold-off so the block backs up
		sender_idle_pct = 0;
		recv_stall_pct = 56;
		hold_cnt = 400;
		repeat (70) send(rand_req());

		// Both sides idle
		sender_idle_pct = 30;
		recv_stall_pct = 30;
		repeat (70) send(rand_req());
		in_valid <= 1'b0;

		wait (pending.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
